[rtl/shp3_pkg.sv]
// ---------------------------------------------------------------------------
// shp3_pkg
// Shared constants, types and register codes for the 3x3 RGB sharpening core.
// ---------------------------------------------------------------------------
package shp3_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int FRAC_BITS  = 8;

  localparam int COL_W   = $clog2(MAX_WIDTH);   // column counter / line address
  localparam int WID_W   = 12;                  // image_width register
  localparam int HGT_W   = 13;                  // image_height register
  localparam int LVL_W   = 12;                  // sharpen_level register
  localparam int CFG_W   = 13;                  // widest register
  localparam int IDX_W   = 2;                   // register index
  localparam int CH_W    = 8;
  localparam int NCH     = 3;
  localparam int PIX_W   = NCH * CH_W;
  localparam int NTAP    = 9;
  localparam int CTR_TAP = 4;
  localparam int CW_W    = LVL_W + 4;           // 8L + 2^F
  localparam int PROD_W  = CH_W + CW_W - FRAC_BITS;
  localparam int SUM_W   = PROD_W + 2;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_LEVEL  = 2'd2;
  localparam logic [IDX_W-1:0] REG_CROSS  = 2'd3;

  localparam logic [WID_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [HGT_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [LVL_W-1:0] LEVEL_RST  = 12'd115;

  // rows: 0 upper line, 1 lower line, 2 incoming row; columns: 0 oldest
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic gen_first;
    logic gen_second;
    logic top;
    logic drain;
    logic left_first;
    logic right_first;
    logic left_second;
  } item_ctl_t;

  typedef struct packed {
    logic valid;
    logic second;
    logic top;
    logic bottom;
    logic left_off;
    logic right_off;
    logic frame_end;
  } tap_ctl_t;

  typedef struct packed {
    logic            frame_end;
    logic            row_end;
    logic [CH_W-1:0] res_c;
    logic [CH_W-1:0] res_b;
    logic [CH_W-1:0] res_a;
  } res_t;

endpackage

[rtl/sharpen_3x3_rgb_stream_core.sv]
// ---------------------------------------------------------------------------
// sharpen_3x3_rgb_stream_core
// 3x3 Laplacian sharpening of a raster stream of 24-bit pixels.
// ---------------------------------------------------------------------------
// Usage: set width, height, level and kernel shape through the cfg port while
// the core is idle, then stream the image on in_* one pixel per word in raster
// order, followed by one drain row of width words whose data is ignored.
// Results leave on out_*: one word per image pixel, lagging one row and one
// column; out_tlast marks the last pixel of an output row and out_tuser the
// last pixel of the frame.
// Throughput: one word per clock while the output queue has room. At the end
// of each input row from the second on, a row wider than one pixel emits two
// results from one input word, and the window stage then holds in_tready low
// while the second one is issued. The line stores sit in one RAM of 2048 x 48
// bits, read when a word is accepted and written back as that word leaves the
// RAM read stage; a one-entry bypass covers width 1. A word then passes the
// window register and the tap product register; sum and clamp feed the queue.
// Reset clears the counters, window and queue and loads the default registers;
// the RAM is not cleared. When out_tready is low a two-word output queue takes
// up the results in flight, then in_tready drops until room frees up.
// ---------------------------------------------------------------------------
module sharpen_3x3_rgb_stream_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [23:0]                  in_tdata,   // chan_a, chan_b, chan_c
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [23:0]                  out_tdata,  // res_a, res_b, res_c
  output logic                         out_tlast,
  output logic                         out_tuser,  // frame_end
  input  logic                         cfg_wr_en,
  input  logic [shp3_pkg::IDX_W-1:0]   cfg_index,
  input  logic [shp3_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int ENT_W = 2 * shp3_pkg::PIX_W;

  // configuration
  logic [shp3_pkg::WID_W-1:0] width_r;
  logic [shp3_pkg::HGT_W-1:0] height_r;
  logic [shp3_pkg::LVL_W-1:0] level_r;
  logic                       cross_r;
  logic [shp3_pkg::WID_W-1:0] eff_w;
  logic [shp3_pkg::HGT_W-1:0] eff_h;

  // input side
  logic [shp3_pkg::COL_W-1:0] col_r, col_nxt;
  logic [shp3_pkg::HGT_W-1:0] row_r, row_nxt;
  logic                       accept;
  logic                       row_end_in;
  logic                       drain_in;

  // pipeline control
  logic adv;
  logic adv_back;
  logic hold_split;

  // stage 1: RAM read in flight
  logic                        s1_v_r;
  logic [shp3_pkg::PIX_W-1:0]  s1_pix_r;
  logic [shp3_pkg::COL_W-1:0]  s1_col_r;
  shp3_pkg::item_ctl_t         s1_ctl_r, s1_ctl_nxt;
  logic                        fwd_r;
  logic [ENT_W-1:0]            fwd_data_r;
  logic [ENT_W-1:0]            ram_rdata;
  logic [ENT_W-1:0]            ent;
  logic                        wr_en;
  logic [ENT_W-1:0]            wr_data;

  // stage 2: window
  shp3_pkg::win_t              win_r;
  logic                        s2_v_r;
  shp3_pkg::item_ctl_t         s2_ctl_r;
  logic                        phase_r;
  logic                        emit_first;
  logic                        emit_second;
  shp3_pkg::tap_ctl_t          tap_ctl;

  // output queue
  logic                        f_valid;
  shp3_pkg::res_t              f_res;
  shp3_pkg::res_t              q_mem_r [2];
  logic                        q_wp_r;
  logic                        q_rp_r;
  logic [1:0]                  q_cnt_r;
  logic                        push;
  logic                        pop;
  shp3_pkg::res_t              q_head;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= shp3_pkg::WIDTH_RST;
      height_r <= shp3_pkg::HEIGHT_RST;
      level_r  <= shp3_pkg::LEVEL_RST;
      cross_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        shp3_pkg::REG_WIDTH:  width_r  <= cfg_wdata[shp3_pkg::WID_W-1:0];
        shp3_pkg::REG_HEIGHT: height_r <= cfg_wdata[shp3_pkg::HGT_W-1:0];
        shp3_pkg::REG_LEVEL:  level_r  <= cfg_wdata[shp3_pkg::LVL_W-1:0];
        shp3_pkg::REG_CROSS:  cross_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      eff_w = shp3_pkg::WID_W'(1);
    end else if (width_r > shp3_pkg::WID_W'(shp3_pkg::MAX_WIDTH)) begin
      eff_w = shp3_pkg::WID_W'(shp3_pkg::MAX_WIDTH);
    end else begin
      eff_w = width_r;
    end
    if (height_r == '0) begin
      eff_h = shp3_pkg::HGT_W'(1);
    end else if (height_r > shp3_pkg::HGT_W'(shp3_pkg::MAX_HEIGHT)) begin
      eff_h = shp3_pkg::HGT_W'(shp3_pkg::MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
  end

  // ---------------- pipeline control ----------------
  assign adv        = !(f_valid && (q_cnt_r == 2'd2));
  assign hold_split = s2_v_r && s2_ctl_r.gen_first && s2_ctl_r.gen_second && !phase_r;
  assign adv_back   = adv && !hold_split;
  assign in_tready  = adv_back;
  assign accept     = in_tvalid && adv_back;

  // ---------------- position counters ----------------
  assign row_end_in = (shp3_pkg::WID_W'(col_r) + 1'b1) >= eff_w;
  assign drain_in   = row_r >= eff_h;

  always_comb begin
    col_nxt = col_r + 1'b1;
    row_nxt = row_r;
    if (row_end_in) begin
      col_nxt = '0;
      row_nxt = drain_in ? '0 : row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_comb begin
    s1_ctl_nxt.gen_first   = (row_r != '0) && (col_r != '0);
    s1_ctl_nxt.gen_second  = (row_r != '0) && row_end_in;
    s1_ctl_nxt.top         = row_r == shp3_pkg::HGT_W'(1);
    s1_ctl_nxt.drain       = drain_in;
    s1_ctl_nxt.left_first  = col_r == shp3_pkg::COL_W'(1);
    s1_ctl_nxt.right_first = shp3_pkg::WID_W'(col_r) >= eff_w;
    s1_ctl_nxt.left_second = col_r == '0;
  end

  // ---------------- stage 1 ----------------
  shp3_line_ram #(
    .DEPTH (shp3_pkg::MAX_WIDTH),
    .WIDTH (ENT_W)
  ) u_line_ram (
    .clk     (clk),
    .rd_en   (adv_back),
    .rd_addr (col_r),
    .rd_data (ram_rdata),
    .wr_en   (wr_en),
    .wr_addr (s1_col_r),
    .wr_data (wr_data)
  );

  // entry: upper line in the high half, lower line in the low half
  assign ent     = fwd_r ? fwd_data_r : ram_rdata;
  assign wr_en   = s1_v_r && adv_back && !s1_ctl_r.drain;
  assign wr_data = {ent[shp3_pkg::PIX_W-1:0], s1_pix_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv_back) begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_back) begin
      s1_pix_r   <= drain_in ? '0 : in_tdata;
      s1_col_r   <= col_r;
      s1_ctl_r   <= s1_ctl_nxt;
      // bypass the entry being written back to the same column
      fwd_r      <= wr_en && (s1_col_r == col_r);
      fwd_data_r <= wr_data;
    end
  end

  // ---------------- stage 2: window ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      s2_v_r  <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      if (adv_back) begin
        s2_v_r <= s1_v_r;
        if (s1_v_r) begin
          for (int k = 0; k < 3; k++) begin
            win_r[k][0] <= win_r[k][1];
            win_r[k][1] <= win_r[k][2];
          end
          win_r[0][2] <= ent[ENT_W-1:shp3_pkg::PIX_W];
          win_r[1][2] <= ent[shp3_pkg::PIX_W-1:0];
          win_r[2][2] <= s1_pix_r;
        end
      end
      if (adv) begin
        phase_r <= hold_split;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_back) begin
      s2_ctl_r <= s1_ctl_r;
    end
  end

  assign emit_first  = s2_v_r && s2_ctl_r.gen_first && !phase_r;
  assign emit_second = s2_v_r && s2_ctl_r.gen_second && (phase_r || !s2_ctl_r.gen_first);

  always_comb begin
    tap_ctl.valid     = emit_first || emit_second;
    tap_ctl.second    = !emit_first;
    tap_ctl.top       = s2_ctl_r.top;
    tap_ctl.bottom    = s2_ctl_r.drain;
    tap_ctl.left_off  = emit_first ? s2_ctl_r.left_first : s2_ctl_r.left_second;
    tap_ctl.right_off = emit_first ? s2_ctl_r.right_first : 1'b1;
    tap_ctl.frame_end = !emit_first && s2_ctl_r.drain;
  end

  shp3_filter u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .ctl       (tap_ctl),
    .win       (win_r),
    .level     (level_r),
    .cross_en  (cross_r),
    .res_valid (f_valid),
    .res       (f_res)
  );

  // ---------------- output queue ----------------
  assign push   = f_valid && adv;
  assign pop    = out_tvalid && out_tready;
  assign q_head = q_mem_r[q_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
      q_cnt_r <= '0;
    end else begin
      if (push) begin
        q_wp_r <= !q_wp_r;
      end
      if (pop) begin
        q_rp_r <= !q_rp_r;
      end
      case ({push, pop})
        2'b10:   q_cnt_r <= q_cnt_r + 1'b1;
        2'b01:   q_cnt_r <= q_cnt_r - 1'b1;
        default: q_cnt_r <= q_cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[q_wp_r] <= f_res;
    end
  end

  assign out_tvalid = q_cnt_r != '0;
  assign out_tdata  = {q_head.res_c, q_head.res_b, q_head.res_a};
  assign out_tlast  = q_head.row_end;
  assign out_tuser  = q_head.frame_end;

endmodule

[rtl/shp3_line_ram.sv]
// ---------------------------------------------------------------------------
// shp3_line_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module shp3_line_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/shp3_filter.sv]
// ---------------------------------------------------------------------------
// shp3_filter
// Kernel datapath: masked tap products per channel, then sum and clamp.
// ---------------------------------------------------------------------------
module shp3_filter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  shp3_pkg::tap_ctl_t           ctl,
  input  shp3_pkg::win_t               win,
  input  logic [shp3_pkg::LVL_W-1:0]   level,
  input  logic                         cross_en,
  output logic                         res_valid,
  output shp3_pkg::res_t               res
);

  logic [shp3_pkg::NCH-1:0][shp3_pkg::NTAP-1:0][shp3_pkg::PROD_W-1:0] prod_nxt, prod_r;
  logic valid_r;
  logic row_end_r;
  logic frame_end_r;
  logic [shp3_pkg::NCH-1:0][shp3_pkg::CH_W-1:0] pix_out;

  // tap products, each truncated on its own
  always_comb begin
    logic [shp3_pkg::CW_W-1:0]               lvl_ext;
    logic [shp3_pkg::CW_W-1:0]               cw;
    logic [shp3_pkg::CW_W-1:0]               wt;
    logic [1:0]                              col;
    logic                                    ok;
    logic [shp3_pkg::CH_W-1:0]               p;
    logic [shp3_pkg::CH_W+shp3_pkg::CW_W-1:0] full;
    lvl_ext = shp3_pkg::CW_W'(level);
    cw = (cross_en ? (lvl_ext << 2) : (lvl_ext << 3))
         + shp3_pkg::CW_W'(1 << shp3_pkg::FRAC_BITS);
    prod_nxt = '0;
    for (int ch = 0; ch < shp3_pkg::NCH; ch++) begin
      for (int ry = 0; ry < 3; ry++) begin
        for (int rx = 0; rx < 3; rx++) begin
          col = 2'(rx + (ctl.second ? 1 : 0));
          ok  = 1'b1;
          if (ry == 0 && ctl.top)       ok = 1'b0;
          if (ry == 2 && ctl.bottom)    ok = 1'b0;
          if (rx == 0 && ctl.left_off)  ok = 1'b0;
          if (rx == 2 && ctl.right_off) ok = 1'b0;
          if (cross_en && ry != 1 && rx != 1) ok = 1'b0;
          p = '0;
          if (ok) begin
            p = win[ry][col][ch*shp3_pkg::CH_W +: shp3_pkg::CH_W];
          end
          wt   = (ry == 1 && rx == 1) ? cw : lvl_ext;
          full = p * wt;
          prod_nxt[ch][ry*3+rx] = full[shp3_pkg::FRAC_BITS +: shp3_pkg::PROD_W];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r      <= prod_nxt;
      row_end_r   <= ctl.second;
      frame_end_r <= ctl.frame_end;
    end
  end

  // centre minus neighbours, clamp to a byte
  always_comb begin
    logic signed [shp3_pkg::SUM_W-1:0] acc;
    for (int ch = 0; ch < shp3_pkg::NCH; ch++) begin
      acc = $signed({2'b00, prod_r[ch][shp3_pkg::CTR_TAP]});
      for (int k = 0; k < shp3_pkg::NTAP; k++) begin
        if (k != shp3_pkg::CTR_TAP) begin
          acc = acc - $signed({2'b00, prod_r[ch][k]});
        end
      end
      if (acc < 0) begin
        pix_out[ch] = '0;
      end else if (acc > 255) begin
        pix_out[ch] = '1;
      end else begin
        pix_out[ch] = acc[shp3_pkg::CH_W-1:0];
      end
    end
  end

  assign res_valid     = valid_r;
  assign res.res_a     = pix_out[0];
  assign res.res_b     = pix_out[1];
  assign res.res_c     = pix_out[2];
  assign res.row_end   = row_end_r;
  assign res.frame_end = frame_end_r;

endmodule

[tb/tb_sharpen_3x3_rgb_stream_core.sv]
// ---------------------------------------------------------------------------
// tb_sharpen_3x3_rgb_stream_core
// Self-checking bench for the 3x3 RGB sharpening stream core.
// ---------------------------------------------------------------------------
// A scoreboard class carries its own line stores, window and counters, and
// computes the filtered pixels for each accepted input word. Every output word
// is compared field by field with the oldest pending pixel. Images run with
// random sizes, levels and kernel shapes (zero sizes and extreme levels among
// them), a register change in the middle of an image, and random gaps on the
// input and stalls on the output.
// ---------------------------------------------------------------------------
module tb_sharpen_3x3_rgb_stream_core;
  import shp3_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  class sharpen_checker;
    logic [PIX_W-1:0] upper_line [MAX_WIDTH];
    logic [PIX_W-1:0] lower_line [MAX_WIDTH];
    win_t             window;
    int               col;
    int               row;
    logic [WID_W-1:0] width;
    logic [HGT_W-1:0] height;
    logic [LVL_W-1:0] level;
    logic             cross_on;
    res_t             pending_pixels [$];
    int               errors;
    int               n_in;
    int               n_out;

    function new();
      foreach (upper_line[i]) upper_line[i] = '0;
      foreach (lower_line[i]) lower_line[i] = '0;
      window   = '0;
      col      = 0;
      row      = 0;
      width    = WIDTH_RST;
      height   = HEIGHT_RST;
      level    = LEVEL_RST;
      cross_on = 1'b0;
      errors   = 0;
      n_in     = 0;
      n_out    = 0;
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_WIDTH:  width    = data[WID_W-1:0];
        REG_HEIGHT: height   = data[HGT_W-1:0];
        REG_LEVEL:  level    = data[LVL_W-1:0];
        REG_CROSS:  cross_on = data[0];
        default: ;
      endcase
    endfunction

    // Kernel applied around the pixel whose center sits in window column ccol.
    function res_t sharpen_at(int ccol, int y, int x, int w, int h,
                              logic last_in_row, logic last_in_frame);
      int                           acc [NCH];
      int                           lvl;
      int                           cw;
      int                           wcol;
      int                           p;
      logic [PIX_W-1:0]             px;
      logic [NCH-1:0][CH_W-1:0]     ch_out;
      res_t                         res;
      lvl = int'(level);
      cw  = (cross_on ? 4 : 8) * lvl + (1 << FRAC_BITS);
      foreach (acc[i]) acc[i] = 0;
      for (int dy = -1; dy <= 1; dy++) begin
        if (dy < 0 && y == 0) continue;
        if (dy > 0 && y + 1 >= h) continue;
        for (int dx = -1; dx <= 1; dx++) begin
          wcol = ccol + dx;
          if (dx < 0 && x == 0) continue;
          if (dx > 0 && x + 1 >= w) continue;
          if (wcol < 0 || wcol > 2) continue;
          if (cross_on && dx != 0 && dy != 0) continue;
          px = window[dy + 1][wcol];
          for (int ch = 0; ch < NCH; ch++) begin
            p = int'(px[ch * CH_W +: CH_W]);
            if (dx == 0 && dy == 0) acc[ch] += (p * cw) >> FRAC_BITS;
            else acc[ch] -= (p * lvl) >> FRAC_BITS;
          end
        end
      end
      foreach (acc[i])
        ch_out[i] = (acc[i] < 0) ? '0 : (acc[i] > 255) ? 8'hFF : CH_W'(acc[i]);
      res.res_a     = ch_out[0];
      res.res_b     = ch_out[1];
      res.res_c     = ch_out[2];
      res.row_end   = last_in_row;
      res.frame_end = last_in_frame;
      return res;
    endfunction

    function void take_pixel(logic [PIX_W-1:0] data);
      int               w;
      int               h;
      logic             drain;
      logic             last_col;
      logic [PIX_W-1:0] pix;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] lo;
      w = (width == 0) ? 1 : (width > MAX_WIDTH) ? MAX_WIDTH : int'(width);
      h = (height == 0) ? 1 : (height > MAX_HEIGHT) ? MAX_HEIGHT : int'(height);
      drain    = (row >= h);
      last_col = (col + 1 >= w);
      pix      = drain ? '0 : data;
      up       = upper_line[col];
      lo       = lower_line[col];
      if (!drain) begin
        upper_line[col] = lo;
        lower_line[col] = pix;
      end
      for (int k = 0; k < 3; k++) begin
        window[k][0] = window[k][1];
        window[k][1] = window[k][2];
      end
      window[0][2] = up;
      window[1][2] = lo;
      window[2][2] = pix;
      if (row >= 1) begin
        if (col >= 1)
          pending_pixels.push_back(sharpen_at(1, row - 1, col - 1, w, h, 1'b0, 1'b0));
        if (last_col)
          pending_pixels.push_back(sharpen_at(2, row - 1, col, w, h, 1'b1, drain));
      end
      if (last_col) begin
        col = 0;
        row = drain ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
      n_in++;
    endfunction

    function void check_pixel(res_t got);
      res_t want;
      n_out++;
      if (pending_pixels.size() == 0) begin
        $error("output word with no pixel pending: %h", got);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      if (got.res_a !== want.res_a) begin
        $error("res_a: expected %0d, got %0d", want.res_a, got.res_a);
        errors++;
      end
      if (got.res_b !== want.res_b) begin
        $error("res_b: expected %0d, got %0d", want.res_b, got.res_b);
        errors++;
      end
      if (got.res_c !== want.res_c) begin
        $error("res_c: expected %0d, got %0d", want.res_c, got.res_c);
        errors++;
      end
      if (got.row_end !== want.row_end) begin
        $error("row_end: expected %0d, got %0d", want.row_end, got.row_end);
        errors++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [23:0]       in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [23:0]       out_tdata;
  logic              out_tlast;
  logic              out_tuser;
  logic              cfg_wr_en  = 1'b0;
  logic [IDX_W-1:0]  cfg_index  = REG_WIDTH;
  logic [CFG_W-1:0]  cfg_wdata  = '0;

  sharpen_checker sb = new();

  bit in_gap_on;
  bit out_stall_on;
  int quiet_cycles;
  int n_frames;

  sharpen_3x3_rgb_stream_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int clip_dim(int v, int top);
    return (v == 0) ? 1 : (v > top) ? top : v;
  endfunction

  function automatic logic [23:0] make_pixel(bit extreme);
    logic [23:0] px;
    px = 24'($urandom);
    if (extreme)
      for (int ch = 0; ch < NCH; ch++)
        case ($urandom_range(0, 2))
          0: px[ch * CH_W +: CH_W] = 8'h00;
          1: px[ch * CH_W +: CH_W] = 8'hFF;
          default: ;
        endcase
    return px;
  endfunction

  // Sample handshakes at the edge, before the core's registers move.
  always @(posedge clk) begin
    bit active;
    if (rst_n) begin
      active = 1'b0;
      if (cfg_wr_en) begin
        sb.write_reg(cfg_index, cfg_wdata);
        active = 1'b1;
      end
      if (in_tvalid && in_tready) begin
        sb.take_pixel(in_tdata);
        active = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        sb.check_pixel(res_t'({out_tuser, out_tlast, out_tdata}));
        active = 1'b1;
      end
      quiet_cycles = active ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_sharpen_3x3_rgb_stream_core failed");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    int stall_left;
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (out_stall_on && $urandom_range(0, 99) < 30) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                              : $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_word(logic [23:0] data);
    int gap;
    gap = in_gap_on ? gap_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_rows(int nrows, int ncols, bit extreme);
    for (int r = 0; r < nrows; r++)
      for (int c = 0; c < ncols; c++)
        send_word(make_pixel(extreme));
  endtask

  // Drop valid, drain every pending pixel, then let the pipeline settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Program all registers, stream the image plus its drain row, wait for idle.
  task automatic run_frame(int w_raw, int h_raw, int lvl, bit cross_sel, bit extreme);
    int w;
    int h;
    cfg_write(REG_WIDTH,  {1'($urandom), WID_W'(w_raw)});
    cfg_write(REG_HEIGHT, HGT_W'(h_raw));
    cfg_write(REG_LEVEL,  {1'($urandom), LVL_W'(lvl)});
    cfg_write(REG_CROSS,  {12'($urandom), cross_sel});
    cfg_wr_en <= 1'b0;
    w = clip_dim(w_raw, MAX_WIDTH);
    h = clip_dim(h_raw, MAX_HEIGHT);
    send_rows(h + 1, w, extreme);
    wait_idle();
    n_frames++;
  endtask

  initial begin
    int w_pick;
    int h_pick;
    int l_pick;
    int r;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: saturating levels on extreme pixels, zero sizes, then a
    // register change in the middle of an image that also cuts it short.
    in_gap_on    = 1'b0;
    out_stall_on = 1'b0;
    run_frame(3, 2, 4095, 1'b0, 1'b1);
    run_frame(0, 0, 0, 1'b1, 1'b1);
    cfg_write(REG_WIDTH,  13'd4);
    cfg_write(REG_HEIGHT, 13'd4);
    cfg_write(REG_LEVEL,  13'd256);
    cfg_write(REG_CROSS,  13'd1);
    cfg_wr_en <= 1'b0;
    send_rows(2, 4, 1'b1);
    wait_idle();
    cfg_write(REG_LEVEL,  13'd4095);
    cfg_write(REG_CROSS,  13'd0);
    cfg_write(REG_HEIGHT, 13'd2);
    cfg_wr_en <= 1'b0;
    send_rows(1, 4, 1'b1);
    wait_idle();
    n_frames++;

    // Random: mostly small images, occasional zero sizes and extreme levels.
    while (sb.n_in < 560) begin
      in_gap_on    = ($urandom_range(0, 9) < 7);
      out_stall_on = ($urandom_range(0, 9) < 7);
      r = $urandom_range(0, 99);
      w_pick = (r < 5) ? 0 : (r < 75) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      h_pick = ($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 8);
      r = $urandom_range(0, 99);
      l_pick = (r < 10) ? 0 : (r < 20) ? 4095 : $urandom_range(0, 4095);
      run_frame(w_pick, h_pick, l_pick, 1'($urandom), ($urandom_range(0, 4) == 0));
    end

    repeat (16) @(posedge clk);
    $display("ran %0d images: %0d input words, %0d output words checked",
             n_frames, sb.n_in, sb.n_out);
    $display("sizes from zero up to 40 by 8, both kernels, levels 0 to 4095, stalls");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_sharpen_3x3_rgb_stream_core passed");
    end else begin
      $display("tb_sharpen_3x3_rgb_stream_core failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/shp3_pkg.sv
rtl/shp3_line_ram.sv
rtl/shp3_filter.sv
rtl/sharpen_3x3_rgb_stream_core.sv
tb/tb_sharpen_3x3_rgb_stream_core.sv
